[rtl/dbmt_pkg.sv]
package dbmt_pkg;

  localparam int BAND_W    = 9;
  localparam int MAG_W     = 16;
  localparam int END_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;

  // Band count table is indexed by the full band field
  localparam int BAND_SLOTS = 1 << BAND_W;

  // Bins at or above this index are never searched
  localparam int NUM_BINS = 512;

  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int CNT_W_DEF        = $clog2(WINDOW_DEPTH_DEF + 1);

  localparam logic [BAND_W-1:0] FIRST_BAND_RST = 9'd0;
  localparam logic [END_W-1:0]  END_BAND_RST   = 10'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_BAND = 1'b0,
    CFG_END_BAND   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_DEC,
    ALU_GT
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST_RD,
    ST_OLD_RD,
    ST_OLD_WR,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic              action;
    logic [BAND_W-1:0] bin_index;
    logic [MAG_W-1:0]  bin_magnitude;
    logic              frame_end;
  } in_t;

  typedef struct packed {
    logic [BAND_W-1:0] frame_band;
    logic [BAND_W-1:0] window_mode;
    logic [BAND_W-1:0] mode_count;
  } out_t;

endpackage

[rtl/dbmt_alu.sv]
module dbmt_alu
  import dbmt_pkg::*;
#(
  parameter int CNT_W = CNT_W_DEF
) (
  input  alu_op_e          op_i,
  input  logic [CNT_W-1:0] a_i,
  input  logic [CNT_W-1:0] b_i,
  output logic [CNT_W-1:0] y_o,
  output logic             gt_o
);

  logic [CNT_W-1:0] addend;
  logic [CNT_W-1:0] sum;

  // One adder serves increment and decrement
  always_comb begin
    case (op_i)
      ALU_INC: addend = CNT_W'(1);
      ALU_DEC: addend = '1;
      default: addend = '0;
    endcase
  end

  assign sum = a_i + addend;

  // Hold a zero count at zero on decrement
  always_comb begin
    case (op_i)
      ALU_DEC: y_o = (a_i == '0) ? '0 : sum;
      default: y_o = sum;
    endcase
  end

  assign gt_o = (a_i > b_i);

endmodule

[rtl/dominant_band_mode_tracker_top.sv]
// Channel  | Signals                                | Role
// ---------+----------------------------------------+-----------------------------
// in       | in_valid_i, in_ready_o, in_data_i      | bin sample or flush request
// out      | out_valid_o, out_ready_i, out_data_o   | frame band and window mode
// cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i       | band range registers
//
// A bin sample without frame end leaves the block ready for the next item. A frame
// end runs a count update through the count table, which has one read and one
// write port, then a pipelined walk over every history slot, one slot per cycle.
// A flush, and reset release, run a clearing pass over max(WINDOW_DEPTH, 512)
// slots of history and count table; no transaction is taken meanwhile.
// A pending result stalls only the next frame end, at its final cycle.
module dominant_band_mode_tracker_top
  import dbmt_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int HW    = $clog2(WINDOW_DEPTH);
  localparam int WIW   = $clog2(WINDOW_DEPTH + 1);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SWEEP = (WINDOW_DEPTH > BAND_SLOTS) ? WINDOW_DEPTH : BAND_SLOTS;
  localparam int SW    = $clog2(SWEEP);

  state_e state_q, state_d;

  logic [BAND_W-1:0] first_band_q;
  logic [END_W-1:0]  end_band_q;

  logic [MAG_W-1:0]  peak_mag_q;
  logic [BAND_W-1:0] peak_band_q;
  logic [BAND_W-1:0] band_q;
  logic [BAND_W-1:0] old_q;
  logic [HW-1:0]     ws_q;
  logic [SW-1:0]     clr_q;

  logic [WIW-1:0]    walk_idx_q;
  logic              v1_q;
  logic              v2_q;
  logic [BAND_W-1:0] b1_q;
  logic [CW-1:0]     best_cnt_q;
  logic [BAND_W-1:0] best_band_q;

  logic              out_valid_q;
  out_t              out_q;

  // History and count memories
  logic [BAND_W-1:0] hist_mem [WINDOW_DEPTH];
  logic [CW-1:0]     cnt_mem  [BAND_SLOTS];
  logic [BAND_W-1:0] hist_rd_q;
  logic [CW-1:0]     cnt_rd_q;

  logic [HW-1:0]     hist_raddr;
  logic              hist_we;
  logic [HW-1:0]     hist_waddr;
  logic [BAND_W-1:0] hist_wdata;
  logic [BAND_W-1:0] cnt_raddr;
  logic              cnt_we;
  logic [BAND_W-1:0] cnt_waddr;
  logic [CW-1:0]     cnt_wdata;

  alu_op_e           alu_op;
  logic [CW-1:0]     alu_y;
  logic              alu_gt;

  logic              in_acc;
  logic              in_range;
  logic              peak_upd;
  logic [BAND_W-1:0] new_band;
  logic              clr_last;
  logic              walk_issue;
  logic              walk_done;
  logic              out_free;

  dbmt_alu #(
    .CNT_W(CW)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (cnt_rd_q),
    .b_i  (best_cnt_q),
    .y_o  (alu_y),
    .gt_o (alu_gt)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Peak search on the incoming bin
  assign in_range = (in_data_i.bin_index >= first_band_q) &&
                    ({1'b0, in_data_i.bin_index} < end_band_q) &&
                    (32'(in_data_i.bin_index) < NUM_BINS);
  assign peak_upd = in_range && (in_data_i.bin_magnitude > peak_mag_q);
  assign new_band = peak_upd ? in_data_i.bin_index : peak_band_q;

  assign clr_last   = (clr_q == SW'(SWEEP - 1));
  assign walk_issue = (walk_idx_q != WIW'(WINDOW_DEPTH));
  assign walk_done  = !walk_issue && !v1_q && !v2_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action)         state_d = ST_CLEAR;
          else if (in_data_i.frame_end) state_d = ST_HIST_RD;
        end
      end
      ST_HIST_RD: state_d = ST_OLD_RD;
      ST_OLD_RD:  state_d = ST_OLD_WR;
      ST_OLD_WR:  state_d = ST_NEW_RD;
      ST_NEW_RD:  state_d = ST_NEW_WR;
      ST_NEW_WR:  state_d = ST_WALK;
      ST_WALK: begin
        if (walk_done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory ports and shared unit control
  always_comb begin
    hist_raddr = ws_q;
    hist_we    = 1'b0;
    hist_waddr = ws_q;
    hist_wdata = band_q;
    cnt_raddr  = band_q;
    cnt_we     = 1'b0;
    cnt_waddr  = band_q;
    cnt_wdata  = alu_y;
    alu_op     = ALU_GT;
    case (state_q)
      ST_CLEAR: begin
        hist_we    = (32'(clr_q) < WINDOW_DEPTH);
        hist_waddr = clr_q[HW-1:0];
        hist_wdata = '0;
        cnt_we     = (32'(clr_q) < BAND_SLOTS);
        cnt_waddr  = clr_q[BAND_W-1:0];
        cnt_wdata  = '0;
      end
      ST_OLD_RD: begin
        cnt_raddr = hist_rd_q;
      end
      ST_OLD_WR: begin
        alu_op    = ALU_DEC;
        cnt_we    = 1'b1;
        cnt_waddr = old_q;
        hist_we   = 1'b1;
      end
      ST_NEW_WR: begin
        alu_op = ALU_INC;
        cnt_we = 1'b1;
      end
      ST_WALK: begin
        hist_raddr = walk_idx_q[HW-1:0];
        cnt_raddr  = hist_rd_q;
      end
      default: ;
    endcase
  end

  // Write and read the memories
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      first_band_q <= FIRST_BAND_RST;
      end_band_q   <= END_BAND_RST;
      peak_mag_q   <= '0;
      peak_band_q  <= '0;
      ws_q         <= '0;
      walk_idx_q   <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FIRST_BAND: first_band_q <= cfg_wdata_i[BAND_W-1:0];
          CFG_END_BAND:   end_band_q   <= cfg_wdata_i[END_W-1:0];
          default: ;
        endcase
      end

      // Advance the clearing sweep
      if (state_q == ST_CLEAR) clr_q <= clr_q + SW'(1);
      else                     clr_q <= '0;

      // Track the peak, restart it at frame end
      if (in_acc && !in_data_i.action) begin
        if (in_data_i.frame_end) begin
          peak_mag_q  <= '0;
          peak_band_q <= '0;
        end else if (peak_upd) begin
          peak_mag_q  <= in_data_i.bin_magnitude;
          peak_band_q <= in_data_i.bin_index;
        end
      end

      // Advance the ring pointer once the slot is written
      if (state_q == ST_NEW_WR) begin
        if (ws_q == HW'(WINDOW_DEPTH - 1)) ws_q <= '0;
        else                               ws_q <= ws_q + HW'(1);
      end

      // Walk pipeline valids
      if (state_q == ST_NEW_WR) begin
        walk_idx_q <= '0;
        v1_q       <= 1'b0;
        v2_q       <= 1'b0;
      end else if (state_q == ST_WALK) begin
        if (walk_issue) walk_idx_q <= walk_idx_q + WIW'(1);
        v1_q <= walk_issue;
        v2_q <= v1_q;
      end

      // Drop the result on transaction, load it at walk end
      if (state_q == ST_WALK && walk_done && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                            out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_data_i.action && in_data_i.frame_end) band_q <= new_band;
    if (state_q == ST_OLD_RD) old_q <= hist_rd_q;
    b1_q <= hist_rd_q;

    if (state_q == ST_NEW_WR) begin
      best_cnt_q  <= '0;
      best_band_q <= '0;
    end else if (state_q == ST_WALK && v2_q && (b1_q != '0) && alu_gt) begin
      best_cnt_q  <= cnt_rd_q;
      best_band_q <= b1_q;
    end

    if (state_q == ST_WALK && walk_done && out_free) begin
      out_q.frame_band  <= band_q;
      out_q.window_mode <= best_band_q;
      out_q.mode_count  <= BAND_W'(best_cnt_q);
    end
  end

endmodule

[rtl/dbmt_checker.sv]
module dbmt_checker
  import dbmt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A frame end starts the slot update, so no transaction in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.action && in_data_i.frame_end |=> !in_ready_o)
    else $error("ready during frame end processing");

  // A flush starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action |=> !in_ready_o)
    else $error("ready during clearing pass");

  // An empty window reports a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.window_mode == '0) |-> (out_data_o.mode_count == '0))
    else $error("nonzero count without a mode band");

endmodule

bind dominant_band_mode_tracker_top dbmt_checker u_dbmt_checker (.*);
